### hw/rtl/assert_macros.svh
// Assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error(msg);

`endif

### hw/rtl/mtrd_pkg.sv
package mtrd_pkg;

    // ring geometry
    localparam int RING_COUNT = 2;
    localparam int RING_DEPTH = 16;
    localparam int RING_W     = (RING_COUNT > 1) ? $clog2(RING_COUNT) : 1;
    localparam int PTR_W      = $clog2(RING_DEPTH);
    localparam int MEM_DEPTH  = RING_COUNT * RING_DEPTH;
    localparam int MEM_AW     = $clog2(MEM_DEPTH);

    // command queue between front and back
    localparam int CMD_FIFO_DEPTH = 2;
    localparam int CMD_FIFO_AW    = $clog2(CMD_FIFO_DEPTH);

    // register port
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 32;
    localparam logic REG_HEADER_BASE = 1'b0;
    localparam logic REG_TRACE_BASE  = 1'b1;

    // dump layout
    localparam logic [15:0] ADDR_STEP   = 16'd2;
    localparam logic [1:0]  HDR_LAST    = 2'd2;

    // input opcodes
    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_TAGGED = 2'd1;
    localparam logic [1:0] OP_DUMP   = 2'd2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [3:0]  channel;
        logic [15:0] value;
        logic [15:0] tag;
    } trace_in_t;

    typedef struct packed {
        logic [15:0] store_address;
        logic [15:0] store_word;
        logic        last;
    } store_out_t;

    typedef enum logic [1:0] {
        CMD_WRITE  = 2'd0,
        CMD_TAGGED = 2'd1,
        CMD_DUMP   = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [RING_W-1:0] ring;
        logic [15:0]       value;
        logic [15:0]       tag;
    } cmd_t;

endpackage

### hw/rtl/mtrd_front.sv
module mtrd_front
    import mtrd_pkg::*;
(
    input  logic      trace_valid,
    output logic      trace_ready,
    input  trace_in_t trace,
    input  logic      fifo_full,
    output logic      push,
    output cmd_t      cmd
);

    logic ch_ok;

    // channel range check, one bit wider so a full count of 16 compares right
    assign ch_ok = ({1'b0, trace.channel} < 5'(RING_COUNT));

    assign trace_ready = !fifo_full;

    // classify; bad channels and unused opcodes are dropped here
    always_comb
    begin
        cmd.ring  = trace.channel[RING_W-1:0];
        cmd.value = trace.value;
        cmd.tag   = trace.tag;
        cmd.kind  = CMD_WRITE;
        push      = 1'b0;
        case (trace.opcode)
            OP_WRITE:
            begin
                cmd.kind = CMD_WRITE;
                push     = trace_valid && !fifo_full && ch_ok;
            end
            OP_TAGGED:
            begin
                cmd.kind = CMD_TAGGED;
                push     = trace_valid && !fifo_full && ch_ok;
            end
            OP_DUMP:
            begin
                cmd.kind = CMD_DUMP;
                push     = trace_valid && !fifo_full;
            end
            default:
            begin
                cmd.kind = CMD_WRITE;
                push     = 1'b0;
            end
        endcase
    end

endmodule

### hw/rtl/mtrd_cmd_fifo.sv
module mtrd_cmd_fifo
    import mtrd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output cmd_t pop_cmd,
    output logic pop_valid
);

    cmd_t                   entry_reg [CMD_FIFO_DEPTH];
    logic [CMD_FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMD_FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMD_FIFO_AW:0]   count_reg, count_next;

    assign full      = (count_reg == (CMD_FIFO_AW+1)'(CMD_FIFO_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_cmd   = entry_reg[rd_ptr_reg];

    // pointer and fill update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == CMD_FIFO_AW'(CMD_FIFO_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (pop && pop_valid)
        begin
            rd_ptr_next = (rd_ptr_reg == CMD_FIFO_AW'(CMD_FIFO_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop && pop_valid})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

### hw/rtl/mtrd_back.sv
module mtrd_back
    import mtrd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    input  cmd_t        cmd,
    output logic        cmd_pop,
    input  logic [15:0] header_base,
    input  logic [15:0] trace_base,
    output logic        store_valid,
    input  logic        store_ready,
    output store_out_t  store
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_TAG  = 5'b00010,
        ST_HDR  = 5'b00100,
        ST_READ = 5'b01000,
        ST_LOAD = 5'b10000
    } back_state_t;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [MEM_AW-1:0] mem_index(input logic [RING_W-1:0] r,
                                                    input logic [PTR_W-1:0] p);
        mem_index = MEM_AW'(r) * MEM_AW'(RING_DEPTH) + MEM_AW'(p);
    endfunction

    back_state_t       state_reg, state_next;
    logic [15:0]       hold_reg, hold_next;
    logic [RING_W-1:0] ring_reg, ring_next;
    logic [PTR_W-1:0]  pos_reg, pos_next;
    logic [PTR_W-1:0]  cnt_reg, cnt_next;
    logic [1:0]        hdr_reg, hdr_next;
    logic [15:0]       addr_reg, addr_next;
    store_out_t        store_reg, store_next;
    logic              store_valid_reg, store_valid_next;

    logic [15:0]          ring_mem_reg [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] valid_reg;
    logic [PTR_W-1:0]     wp_reg [RING_COUNT];
    logic [15:0]          rdata_reg;
    logic                 rvalid_reg;

    logic              slot_free;
    logic              mem_we;
    logic [15:0]       mem_wdata;
    logic              mem_re;
    logic [MEM_AW-1:0] mem_raddr;
    logic [RING_W-1:0] ptr_sel;
    logic [PTR_W-1:0]  wp_sel;
    logic [PTR_W-1:0]  rd_pos;
    logic              final_word;
    logic [15:0]       hdr_word;

    assign slot_free   = !store_valid_reg || store_ready;
    assign store_valid = store_valid_reg;
    assign store       = store_reg;

    // one pointer read port: command ring when idle, held ring otherwise
    assign ptr_sel    = (state_reg == ST_IDLE) ? cmd.ring : ring_reg;
    assign wp_sel     = wp_reg[ptr_sel];
    assign rd_pos     = (cnt_reg == '0) ? wp_sel : pos_reg;
    assign mem_raddr  = mem_index(ring_reg, rd_pos);
    assign final_word = (ring_reg == RING_W'(RING_COUNT - 1)) &&
                        (cnt_reg == PTR_W'(RING_DEPTH - 1));

    // header words: trace base, ring count, ring depth
    always_comb
    begin
        case (hdr_reg)
            2'd0:    hdr_word = trace_base;
            2'd1:    hdr_word = 16'(RING_COUNT);
            default: hdr_word = 16'(RING_DEPTH);
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        hold_next        = hold_reg;
        ring_next        = ring_reg;
        pos_next         = pos_reg;
        cnt_next         = cnt_reg;
        hdr_next         = hdr_reg;
        addr_next        = addr_reg;
        store_next       = store_reg;
        store_valid_next = store_valid_reg && !store_ready;
        cmd_pop          = 1'b0;
        mem_we           = 1'b0;
        mem_wdata        = cmd.value;
        mem_re           = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    case (cmd.kind)
                        CMD_WRITE:
                        begin
                            mem_we    = 1'b1;
                            mem_wdata = cmd.value;
                        end
                        CMD_TAGGED:
                        begin
                            mem_we     = 1'b1;
                            mem_wdata  = cmd.tag;
                            hold_next  = cmd.value;
                            ring_next  = cmd.ring;
                            state_next = ST_TAG;
                        end
                        CMD_DUMP:
                        begin
                            hdr_next   = '0;
                            ring_next  = '0;
                            cnt_next   = '0;
                            addr_next  = trace_base;
                            state_next = ST_HDR;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_TAG:
            begin
                mem_we     = 1'b1;
                mem_wdata  = hold_reg;
                state_next = ST_IDLE;
            end
            ST_HDR:
            begin
                if (slot_free)
                begin
                    store_next.store_address = header_base + {13'd0, hdr_reg, 1'b0};
                    store_next.store_word    = hdr_word;
                    store_next.last          = 1'b0;
                    store_valid_next         = 1'b1;
                    hdr_next                 = hdr_reg + 1'b1;
                    if (hdr_reg == HDR_LAST)
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                mem_re     = 1'b1;
                pos_next   = ptr_inc(rd_pos);
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (slot_free)
                begin
                    store_next.store_address = addr_reg;
                    store_next.store_word    = rvalid_reg ? rdata_reg : 16'd0;
                    store_next.last          = final_word;
                    store_valid_next         = 1'b1;
                    addr_next                = addr_reg + ADDR_STEP;
                    if (cnt_reg == PTR_W'(RING_DEPTH - 1))
                    begin
                        cnt_next  = '0;
                        ring_next = ring_reg + 1'b1;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                    state_next = final_word ? ST_IDLE : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            store_valid_reg <= 1'b0;
            ring_reg        <= '0;
            pos_reg         <= '0;
            cnt_reg         <= '0;
            hdr_reg         <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            store_valid_reg <= store_valid_next;
            ring_reg        <= ring_next;
            pos_reg         <= pos_next;
            cnt_reg         <= cnt_next;
            hdr_reg         <= hdr_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        hold_reg  <= hold_next;
        addr_reg  <= addr_next;
        store_reg <= store_next;
    end

    // write pointers and entry valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            for (int i = 0; i < RING_COUNT; i++)
            begin
                wp_reg[i] <= '0;
            end
        end
        else if (mem_we)
        begin
            valid_reg[mem_index(ptr_sel, wp_sel)] <= 1'b1;
            wp_reg[ptr_sel] <= ptr_inc(wp_sel);
        end
    end

    // ring memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ring_mem_reg[mem_index(ptr_sel, wp_sel)] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg  <= ring_mem_reg[mem_raddr];
            rvalid_reg <= valid_reg[mem_raddr];
        end
    end

endmodule

### hw/rtl/multichannel_trace_ring_dump.sv
// Trace writes: one word per cycle while the queue is not full; a tagged write holds the
// back end in ST_TAG to write the value after the tag. Results come only from a dump:
// 3 header words, then each ring word by a registered memory read and an output load.
// With the queue empty, the first header word passes the queue, ST_HDR and store registers.
// Reset (rst_n low, asynchronous) empties the queue, zeroes pointers and control registers,
// and marks every ring entry unwritten so it reads as zero.
module multichannel_trace_ring_dump
    import mtrd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready,
    input  logic              trace_valid,
    output logic              trace_ready,
    input  trace_in_t         trace,
    output logic              store_valid,
    input  logic              store_ready,
    output store_out_t        store
);

    logic [15:0] header_base_reg;
    logic [15:0] trace_base_reg;
    logic        cfg_write;
    logic        fifo_full;
    logic        push;
    cmd_t        push_cmd;
    logic        cmd_pop;
    logic        cmd_valid;
    cmd_t        cmd;

    // register port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_base_reg <= '0;
            trace_base_reg  <= '0;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_HEADER_BASE: header_base_reg <= pwdata[15:0];
                REG_TRACE_BASE:  trace_base_reg  <= pwdata[15:0];
                default:         header_base_reg <= header_base_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_HEADER_BASE: prdata = {16'd0, header_base_reg};
            REG_TRACE_BASE:  prdata = {16'd0, trace_base_reg};
            default:         prdata = '0;
        endcase
    end

    mtrd_front u_front (
        .trace_valid (trace_valid),
        .trace_ready (trace_ready),
        .trace       (trace),
        .fifo_full   (fifo_full),
        .push        (push),
        .cmd         (push_cmd)
    );

    mtrd_cmd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (fifo_full),
        .pop       (cmd_pop),
        .pop_cmd   (cmd),
        .pop_valid (cmd_valid)
    );

    mtrd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_pop     (cmd_pop),
        .header_base (header_base_reg),
        .trace_base  (trace_base_reg),
        .store_valid (store_valid),
        .store_ready (store_ready),
        .store       (store)
    );

endmodule

### hw/rtl/mtrd_checker.sv
`include "assert_macros.svh"

module mtrd_checker
    import mtrd_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       store_valid,
    input logic       store_ready,
    input store_out_t store
);

    // nothing is offered in the first cycle out of reset
    `ASSERT_IMPLIES(a_reset_quiet, clk, rst_n, $rose(rst_n), !store_valid, "word valid out of reset")

    // an offered word carries no unknown bits
    `ASSERT_IMPLIES(a_word_known, clk, rst_n, store_valid, !$isunknown(store), "unknown store word")

    // a stalled word holds
    `ASSERT_NEXT(a_stall_hold, clk, rst_n, store_valid && !store_ready, store_valid && $stable(store), "stalled word changed")

endmodule

bind multichannel_trace_ring_dump mtrd_checker u_checker (.*);
